/* rtl/core/rmst_pkg.sv */
// Shared constants, state encoding and controller/datapath link types for the
// range-maximum segment tree core. No dependencies.
package rmst_pkg;

    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;
    localparam int POS_BITS       = 11;  // position / right_end field width
    localparam int DATA_BITS      = 32;  // value / range_max field width
    localparam int POS_CMP_BITS   = 17;  // holds any position and LEAVES up to 65536
    localparam int S_TDATA_BITS   = 56;  // position, right_end, value, zero pad
    localparam int M_TDATA_BITS   = 32;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_code_t;

    typedef enum logic [5:0]
    {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_QWALK  = 6'b001000,
        ST_QDRAIN = 6'b010000,
        ST_QOUT   = 6'b100000
    } state_t;

    typedef struct packed
    {
        logic clr_step;
        logic ld_start;
        logic ld_step;
        logic q_start;
        logic q_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed
    {
        logic clr_last;
        logic ld_ok;
        logic ld_last;
        logic walk_done;
    } dp_sts_t;

endpackage

/* rtl/core/rmst_ctrl.sv */
// Sequencer for the segment tree core: clear sweep, leaf update walk, query
// walk and result hand-off. Depends on rmst_pkg.
module rmst_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_cmd,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rmst_pkg::dp_cmd_t cmd,
    input  rmst_pkg::dp_sts_t sts
);

    rmst_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmst_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == rmst_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            rmst_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_cmd == rmst_pkg::CMD_QUERY)
                    begin
                        cmd.q_start = 1'b1;
                        state_next  = rmst_pkg::ST_QWALK;
                    end
                    else if (sts.ld_ok)
                    begin
                        cmd.ld_start = 1'b1;
                        state_next   = rmst_pkg::ST_LOAD;
                    end
                end
            end
            rmst_pkg::ST_LOAD:
            begin
                cmd.ld_step = 1'b1;
                if (sts.ld_last)
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_QWALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = rmst_pkg::ST_QDRAIN;
                end
                else
                begin
                    cmd.q_step = 1'b1;
                end
            end
            rmst_pkg::ST_QDRAIN:
            begin
                // the last node reads have already folded into the running max; nothing to do here
                state_next = rmst_pkg::ST_QOUT;
            end
            rmst_pkg::ST_QOUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rmst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmst_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/rmst_dpath.sv */
// Datapath for the segment tree core: node memory, leaf update walk, query
// bounds walk, running max and result register. Depends on rmst_pkg.
module rmst_dpath
#(
    parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  rmst_pkg::dp_cmd_t              cmd,
    output rmst_pkg::dp_sts_t              sts,
    input  logic [rmst_pkg::POS_BITS-1:0]  in_position,
    input  logic [rmst_pkg::POS_BITS-1:0]  in_right_end,
    input  logic [rmst_pkg::DATA_BITS-1:0] in_value,
    output logic [rmst_pkg::DATA_BITS-1:0] range_max
);

    localparam int SPAN_LOG = (LEAVES <= 2) ? 1 : $clog2(LEAVES);
    localparam int SPAN     = 1 << SPAN_LOG;
    localparam int NB       = SPAN_LOG + 1;   // node index bits
    localparam int IW       = NB + 1;         // walk bounds, room for l+1 past the end
    localparam int DEPTH    = 2 * SPAN;
    localparam int CW       = rmst_pkg::POS_CMP_BITS;
    localparam int VB       = VALUE_BITS;
    localparam int DW       = rmst_pkg::DATA_BITS;

    localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
    localparam logic [CW:0]   SPAN_M1  = (CW+1)'(SPAN - 1);

    logic [VB-1:0] mem [DEPTH];

    logic [CW-1:0] pos_w, rend_w, left_c, right_c;
    logic          q_empty;
    logic [IW-1:0] l_init, r_init, l_reg, r_reg, l_step, r_step;
    logic [NB-1:0] leaf, node_reg, parent, clr_cnt_reg;
    logic [VB-1:0] val_in, cur_reg, cur_max, rd_a, rd_b, best_reg, best_mid, best_next;
    logic [VB-1:0] out_reg, wd;
    logic [NB-1:0] wa, ra, rb;
    logic          we, take_a_reg, take_b_reg;

    // bounds clamp and leaf indices
    assign pos_w   = CW'(in_position);
    assign rend_w  = CW'(in_right_end);
    assign left_c  = (pos_w == '0) ? CW'(1) : pos_w;
    assign right_c = (rend_w > LEAVES_C) ? LEAVES_C : rend_w;
    assign q_empty = (left_c > right_c);
    assign l_init  = IW'({1'b0, left_c} + SPAN_M1);
    assign r_init  = IW'({1'b0, right_c} + SPAN_M1);
    assign leaf    = NB'({1'b0, pos_w} + SPAN_M1);
    assign val_in  = VB'(in_value);

    assign parent  = node_reg >> 1;
    assign cur_max = (rd_a > cur_reg) ? rd_a : cur_reg;

    assign l_step  = (l_reg + IW'(l_reg[0])) >> 1;
    assign r_step  = (r_reg - IW'(!r_reg[0])) >> 1;

    assign sts.clr_last  = (clr_cnt_reg == NB'(DEPTH - 1));
    assign sts.ld_ok     = (pos_w != '0) && (pos_w <= LEAVES_C);
    assign sts.ld_last   = (parent == NB'(1));
    assign sts.walk_done = (l_reg > r_reg);

    // memory port selection
    always_comb
    begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
            wa = clr_cnt_reg;
        end
        else if (cmd.ld_start)
        begin
            we = 1'b1;
            wa = leaf;
            wd = val_in;
        end
        else if (cmd.ld_step)
        begin
            we = 1'b1;
            wa = parent;
            wd = cur_max;
        end
    end

    always_comb
    begin
        if (cmd.ld_start)
        begin
            ra = leaf ^ NB'(1);
        end
        else if (cmd.ld_step)
        begin
            ra = parent ^ NB'(1);
        end
        else
        begin
            ra = l_reg[NB-1:0];
        end
    end

    assign rb = r_reg[NB-1:0];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a <= mem[ra];
        rd_b <= mem[rb];
    end

    // update walk: carry the path value, pair it with the sibling read
    always_ff @(posedge clk)
    begin
        if (cmd.ld_start)
        begin
            node_reg <= leaf;
            cur_reg  <= val_in;
        end
        else if (cmd.ld_step)
        begin
            node_reg <= parent;
            cur_reg  <= cur_max;
        end
    end

    // query walk bounds; an empty range starts with l above r
    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            l_reg <= q_empty ? IW'(1) : l_init;
            r_reg <= q_empty ? '0 : r_init;
        end
        else if (cmd.q_step)
        begin
            l_reg <= l_step;
            r_reg <= r_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_a_reg  <= 1'b0;
            take_b_reg  <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            take_a_reg <= cmd.q_step & l_reg[0];
            take_b_reg <= cmd.q_step & ~r_reg[0];
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NB'(1);
            end
        end
    end

    assign best_mid  = (take_a_reg && (rd_a > best_reg)) ? rd_a : best_reg;
    assign best_next = (take_b_reg && (rd_b > best_mid)) ? rd_b : best_mid;

    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            best_reg <= '0;
        end
        else
        begin
            best_reg <= best_next;
        end
        if (cmd.out_load)
        begin
            out_reg <= best_reg;
        end
    end

    assign range_max = DW'(out_reg);

endmodule

/* rtl/core/range_max_segment_tree_core.sv */
// Top level of the range-maximum segment tree core: stream ports, controller
// and datapath. Depends on rmst_pkg, rmst_ctrl and rmst_dpath.
//
// Usage:
//   Slave channel (s_*) carries one command per transaction. tuser selects
//   the kind: load (0) writes value at a 1-based position and refreshes the
//   maxima up to the root; query (1) asks for the max over position..right_end.
//   Master channel (m_*) returns one range_max per query; loads return nothing.
//   Query bounds are clamped to 1..LEAVES; an empty range returns 0. Loads to
//   position 0 or above LEAVES are dropped.
// Operation (SPAN = smallest power of two >= max(2, LEAVES)):
//   load : busy while it walks up, one sibling read and one parent write per level
//   query: one level per cycle, both bounds read through the two memory read
//          ports, then drain and output load
//   One command is in flight at a time; s_tready is high only while idle.
// Reset: the node memory is swept to zero, one node per cycle, all 2*SPAN nodes
//   (2048 with defaults) before s_tready first rises.
// Back-pressure: a result waits in the output register while m_tready is low;
//   the next command is still taken, and a following query holds its result
//   in the core until the output register frees up.
module range_max_segment_tree_core
#(
    parameter int LEAVES     = rmst_pkg::LEAVES_DEF,
    parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: position[10:0], right_end[21:11], value[53:22], pad
    input  logic [rmst_pkg::S_TDATA_BITS-1:0] s_tdata,
    // fields from bit 0: command
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fields from bit 0: range_max[31:0]
    output logic [rmst_pkg::M_TDATA_BITS-1:0] m_tdata
);

    localparam int PB = rmst_pkg::POS_BITS;
    localparam int DB = rmst_pkg::DATA_BITS;

    rmst_pkg::dp_cmd_t dp_cmd;
    rmst_pkg::dp_sts_t dp_sts;

    logic [PB-1:0] in_position, in_right_end;
    logic [DB-1:0] in_value;

    // unpack the command transaction
    assign in_position  = s_tdata[PB-1:0];
    assign in_right_end = s_tdata[2*PB-1:PB];
    assign in_value     = s_tdata[2*PB+DB-1:2*PB];

    rmst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    rmst_dpath
    #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .sts          (dp_sts),
        .in_position  (in_position),
        .in_right_end (in_right_end),
        .in_value     (in_value),
        .range_max    (m_tdata)
    );

endmodule

/* tb/range_max_segment_tree_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for range_max_segment_tree_core: directed table, then random
// loads and range-max queries, every result checked. Depends on rmst_pkg and the core.
module range_max_segment_tree_core_test;

    localparam int NUM_LEAVES   = rmst_pkg::LEAVES_DEF;
    localparam int PW           = rmst_pkg::POS_BITS;
    localparam int RANDOM_ITEMS = 1700;
    localparam int DRAIN_EVERY  = 400;   // forced drain of the result queue
    localparam int MODE_EVERY   = 128;   // how often the idling mode is redrawn
    localparam int TAIL_CYCLES  = 50;    // idle time after the last result before the end
    localparam int TAIL_LIMIT   = 5000;

    // one row of the directed table; typed = expected max written in the row
    typedef struct packed
    {
        rmst_pkg::cmd_code_t cmd;
        logic [PW-1:0]       pos;
        logic [PW-1:0]       rend;
        logic [31:0]         val;
        logic                typed;
        logic [31:0]         typed_max;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 24;

    logic                              clk;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    // fields from bit 0: position[10:0], right_end[21:11], value[53:22], pad
    logic [rmst_pkg::S_TDATA_BITS-1:0] s_tdata;
    // fields from bit 0: command
    logic [0:0]                        s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    // fields from bit 0: range_max[31:0]
    logic [rmst_pkg::M_TDATA_BITS-1:0] m_tdata;

    // shadow of the leaves; the max of a range is found by a plain scan
    logic [31:0] leaf_vals [1:NUM_LEAVES];
    // range maxima still owed by the core, oldest first
    logic [31:0] pending_max [$];
    int          mismatch_count;
    bit          quiet_phase;        // both sides run without idling

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // cleared tree: everything is zero, also over the clamped full span
        '{rmst_pkg::CMD_QUERY, 11'd1,    11'd1024, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{rmst_pkg::CMD_QUERY, 11'd0,    11'd2047, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
        // value extremes at both end leaves
        '{rmst_pkg::CMD_LOAD,  11'd1,    11'd2047, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1,    11'd1,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{rmst_pkg::CMD_LOAD,  11'd1024, 11'd0,    32'h0000_0001, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1024, 11'd1024, 32'h0000_0000, 1'b1, 32'h0000_0001},
        // unwritten leaves stay zero
        '{rmst_pkg::CMD_QUERY, 11'd2,    11'd1023, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // empty range, and a range that is empty once clamped
        '{rmst_pkg::CMD_QUERY, 11'd5,    11'd3,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{rmst_pkg::CMD_QUERY, 11'd1025, 11'd2047, 32'h0000_0000, 1'b1, 32'h0000_0000},
        // loads off the ends are dropped
        '{rmst_pkg::CMD_LOAD,  11'd0,    11'd0,    32'hDEAD_BEEF, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd0,    11'd1,    32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
        '{rmst_pkg::CMD_LOAD,  11'd1025, 11'd5,    32'h1234_5678, 1'b0, 32'h0},
        '{rmst_pkg::CMD_LOAD,  11'd2047, 11'd2047, 32'hAAAA_AAAA, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1000, 11'd2047, 32'h0000_0000, 1'b1, 32'h0000_0001},
        // neighbors across the middle of the tree
        '{rmst_pkg::CMD_LOAD,  11'd512,  11'd0,    32'h8000_0000, 1'b0, 32'h0},
        '{rmst_pkg::CMD_LOAD,  11'd513,  11'd0,    32'h7FFF_FFFF, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd2,    11'd1024, 32'h0000_0000, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd513,  11'd1024, 32'h0000_0000, 1'b0, 32'h0},
        // overwrite with a smaller value must lower the path maxima
        '{rmst_pkg::CMD_LOAD,  11'd1,    11'd0,    32'h0000_0000, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1,    11'd511,  32'h0000_0000, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1,    11'd1024, 32'h0000_0000, 1'b0, 32'h0},
        '{rmst_pkg::CMD_LOAD,  11'd1365, 11'd1365, 32'h5555_5555, 1'b0, 32'h0},
        '{rmst_pkg::CMD_QUERY, 11'd1024, 11'd1,    32'h0000_0000, 1'b1, 32'h0000_0000},
        '{rmst_pkg::CMD_QUERY, 11'd0,    11'd0,    32'h0000_0000, 1'b1, 32'h0000_0000}
    };

    range_max_segment_tree_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // hard stop in case the core hangs
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // bounds clamp to 1..LEAVES, empty range gives 0
    function automatic logic [31:0] max_over_range(input logic [PW-1:0] left,
                                                   input logic [PW-1:0] right);
        int          lo;
        int          hi;
        logic [31:0] best;
        lo   = (left < 1) ? 1 : int'(left);
        hi   = (right > NUM_LEAVES) ? NUM_LEAVES : int'(right);
        best = '0;
        for (int i = lo; i <= hi; i++)
        begin
            if (leaf_vals[i] > best)
                best = leaf_vals[i];
        end
        return best;
    endfunction

    // drives one command transaction and updates the shadow when it is taken
    task automatic send_cmd(input rmst_pkg::cmd_code_t cmd, input logic [PW-1:0] pos,
                            input logic [PW-1:0] rend, input logic [31:0] val,
                            input logic typed, input logic [31:0] typed_max);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, val, rend, pos};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == rmst_pkg::CMD_LOAD)
        begin
            if (pos >= 1 && pos <= NUM_LEAVES)
                leaf_vals[pos] = val;
        end
        else
        begin
            pending_max.push_back(typed ? typed_max : max_over_range(pos, rend));
        end
    endtask

    // sender holds off until every owed result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_max.size() != 0);
    endtask

    // result side: random stalls, each result checked against the oldest owed max
    initial
    begin : result_side
        int          stall;
        logic [31:0] want;
        forever
        begin
            stall = quiet_phase ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            if (pending_max.size() == 0)
            begin
                $display("%0t: unexpected range_max, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = pending_max.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: range_max mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : command_side
        int                  taken;
        int                  pick;
        int                  waited;
        rmst_pkg::cmd_code_t cmd;
        logic [PW-1:0]       pos;
        logic [PW-1:0]       rend;
        logic [31:0]         val;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= '0;
        mismatch_count  = 0;
        quiet_phase     = 1'b0;
        for (int i = 1; i <= NUM_LEAVES; i++)
            leaf_vals[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; the first handshake also waits out the reset clearing pass
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].pos, directed_rows[i].rend,
                     directed_rows[i].val, directed_rows[i].typed,
                     directed_rows[i].typed_max);
        drain_results();

        // random part; dropped loads do not count toward the total
        taken = 0;
        while (taken < RANDOM_ITEMS)
        begin
            if (taken % MODE_EVERY == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            rend = PW'($urandom_range(0, 2047));
            val  = $urandom;
            if (pick < 50)
            begin
                cmd = rmst_pkg::CMD_LOAD;
                if (pick >= 45)
                    // off the ends: position 0 or above LEAVES
                    pos = ($urandom_range(0, 1) != 0) ? 11'd0
                                                      : PW'($urandom_range(1025, 2047));
                else if ($urandom_range(0, 9) < 3)
                    pos = PW'($urandom_range(1, 32));     // hot spot, many overwrites
                else
                    pos = PW'($urandom_range(1, NUM_LEAVES));
                case ($urandom_range(0, 9))
                    0: val = 32'hFFFF_FFFF;
                    1: val = 32'h0000_0000;
                    2, 3: val = $urandom_range(0, 255);
                    default: val = $urandom;
                endcase
            end
            else
            begin
                cmd = rmst_pkg::CMD_QUERY;
                if (pick < 70)
                begin
                    pos  = PW'($urandom_range(1, NUM_LEAVES));
                    rend = ((pos + $urandom_range(0, 15)) > NUM_LEAVES) ? PW'(NUM_LEAVES)
                           : pos + PW'($urandom_range(0, 15));
                end
                else if (pick < 85)
                begin
                    pos  = PW'($urandom_range(1, NUM_LEAVES));
                    rend = PW'($urandom_range(pos, NUM_LEAVES));
                end
                else if (pick < 93)
                begin
                    // around and past both ends
                    pos  = PW'($urandom_range(0, 4));
                    rend = PW'($urandom_range(1020, 2047));
                end
                else
                begin
                    // anything the fields hold, often empty
                    pos  = PW'($urandom_range(0, 2047));
                    rend = PW'($urandom_range(0, 2047));
                end
            end
            send_cmd(cmd, pos, rend, val, 1'b0, 32'h0);
            if (cmd == rmst_pkg::CMD_QUERY || (pos >= 1 && pos <= NUM_LEAVES))
            begin
                taken++;
                if (taken % DRAIN_EVERY == 0)
                    drain_results();
            end
        end
        s_tvalid <= 1'b0;

        waited = 0;
        while (pending_max.size() != 0 && waited < TAIL_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_max.size() != 0)
        begin
            $display("%0t: %0d range_max results never arrived, first expected %h",
                     $time, pending_max.size(), pending_max[0]);
            mismatch_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
